// ===== hdl/ttcs_pkg.sv =====
package ttcs_pkg;

   // Default geometry of the history store and the screen.
   localparam int COLUMNS_DEF      = 80;
   localparam int SCREEN_ROWS_DEF  = 25;
   localparam int HISTORY_ROWS_DEF = 64;

   // Cell encoding: attribute in the high byte, character in the low byte.
   localparam logic [7:0] BLANK_CHAR   = 8'h20;
   localparam logic [7:0] NEWLINE_CHAR = 8'd10;
   localparam logic [7:0] CR_CHAR      = 8'd13;
   localparam logic [7:0] TAB_CHAR     = 8'd9;
   localparam logic [7:0] BS_CHAR      = 8'd8;
   localparam logic [7:0] RESET_COLOR  = 8'd15;

   // Item kinds and arrow directions as they arrive on the input.
   localparam logic [1:0] KIND_CHAR   = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_ARROW  = 2'd2;
   localparam logic [1:0] KIND_READ   = 2'd3;
   localparam logic [1:0] DIR_LEFT    = 2'd0;
   localparam logic [1:0] DIR_RIGHT   = 2'd1;
   localparam logic [1:0] DIR_UP      = 2'd2;
   localparam logic [1:0] DIR_DOWN    = 2'd3;

   // Operations after classification.
   typedef enum logic [3:0] {
      OP_NOP     = 4'd0,
      OP_CHAR    = 4'd1,
      OP_NEWLINE = 4'd2,
      OP_DELETE  = 4'd3,
      OP_LEFT    = 4'd4,
      OP_RIGHT   = 4'd5,
      OP_UP      = 4'd6,
      OP_DOWN    = 4'd7,
      OP_READ    = 4'd8
   } op_code_type;

   // One classified item as it travels from the front to the back.
   typedef struct packed {
      op_code_type op;
      logic [7:0]  ch;
      logic [5:0]  rr;
      logic [6:0]  rc;
   } op_type;

endpackage

// ===== hdl/ttcs_ram.sv =====
module ttcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 5120
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ttcs_front.sv =====
module ttcs_front #(
   parameter int COLUMNS      = ttcs_pkg::COLUMNS_DEF,
   parameter int HISTORY_ROWS = ttcs_pkg::HISTORY_ROWS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [1:0]       req_kind,
   input  logic [7:0]       req_char_code,
   input  logic [1:0]       req_direction,
   input  logic [5:0]       req_read_row,
   input  logic [6:0]       req_read_col,
   output logic             op_valid,
   output ttcs_pkg::op_type op_out,
   input  logic             op_take
);

   ttcs_pkg::op_type cls;
   ttcs_pkg::op_type q_ff [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   // Classify the incoming item into one operation.
   always_comb begin
      cls.ch = req_char_code;
      cls.rr = req_read_row;
      cls.rc = req_read_col;
      cls.op = ttcs_pkg::OP_NOP;
      case (req_kind)
         ttcs_pkg::KIND_CHAR: begin
            if (req_char_code == ttcs_pkg::NEWLINE_CHAR) begin
               cls.op = ttcs_pkg::OP_NEWLINE;
            end else if (req_char_code == ttcs_pkg::CR_CHAR ||
                         req_char_code == ttcs_pkg::TAB_CHAR ||
                         req_char_code == ttcs_pkg::BS_CHAR) begin
               cls.op = ttcs_pkg::OP_NOP;
            end else begin
               cls.op = ttcs_pkg::OP_CHAR;
            end
         end
         ttcs_pkg::KIND_DELETE: cls.op = ttcs_pkg::OP_DELETE;
         ttcs_pkg::KIND_ARROW: begin
            case (req_direction)
               ttcs_pkg::DIR_LEFT:  cls.op = ttcs_pkg::OP_LEFT;
               ttcs_pkg::DIR_RIGHT: cls.op = ttcs_pkg::OP_RIGHT;
               ttcs_pkg::DIR_UP:    cls.op = ttcs_pkg::OP_UP;
               default:             cls.op = ttcs_pkg::OP_DOWN;
            endcase
         end
         default: begin
            // A read outside the store becomes a no-op and reports cell data of zero.
            if (32'(req_read_row) < HISTORY_ROWS && 32'(req_read_col) < COLUMNS) begin
               cls.op = ttcs_pkg::OP_READ;
            end else begin
               cls.op = ttcs_pkg::OP_NOP;
            end
         end
      endcase
   end

   // Two-entry queue toward the back.
   assign full     = (cnt_ff == 2'd2);
   assign op_valid = (cnt_ff != 2'd0);
   assign op_out   = q_ff[rp_ff];
   assign do_push  = push && !full;
   assign do_pop   = op_take && op_valid;

   always_comb begin
      wp_in  = do_push ? !wp_ff : wp_ff;
      rp_in  = do_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         q_ff[wp_ff] <= cls;
      end
   end

endmodule

// ===== hdl/ttcs_back.sv =====
module ttcs_back #(
   parameter int COLUMNS      = ttcs_pkg::COLUMNS_DEF,
   parameter int SCREEN_ROWS  = ttcs_pkg::SCREEN_ROWS_DEF,
   parameter int HISTORY_ROWS = ttcs_pkg::HISTORY_ROWS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   input  logic             op_valid,
   input  ttcs_pkg::op_type op_in,
   output logic             op_take,
   output logic             empty,
   input  logic             pop,
   output logic [6:0]       rsp_cursor_col,
   output logic [5:0]       rsp_cursor_row,
   output logic [4:0]       rsp_screen_row,
   output logic [5:0]       rsp_viewport_top,
   output logic [15:0]      rsp_cell_data
);

   localparam int CELLS  = COLUMNS * HISTORY_ROWS;
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int LEN_W  = $clog2(COLUMNS + 1);
   localparam int ROW_W  = $clog2(HISTORY_ROWS);
   localparam int ADDR_W = $clog2(CELLS);
   localparam int SCROLL_VT = (HISTORY_ROWS >= SCREEN_ROWS) ? HISTORY_ROWS - SCREEN_ROWS : 0;

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_SCAN   = 6'b000100,
      S_POST   = 6'b001000,
      S_SCROLL = 6'b010000,
      S_READ   = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [ROW_W-1:0] row_ff, row_in, vt_ff, vt_in, base_ff, base_in;
   logic [ROW_W-1:0] scan_row_ff, scan_row_in, sprow_ff, sprow_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [LEN_W-1:0] x_ff, x_in, chk_x_ff, chk_x_in, len_ff, len_in;
   logic             chk_v_ff, chk_v_in, phase_ff, phase_in;
   logic [7:0]       color_ff;
   ttcs_pkg::op_type cur_op_ff, cur_op_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic             rsp_v_ff;
   logic [15:0]      cell_in;
   logic             finish;

   logic             wr_en, wr_clear, wr_scroll;
   logic [COL_W-1:0] wr_col, rd_col;
   logic [15:0]      wr_data, rd_data;
   logic [ROW_W-1:0] rd_row;
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   // Row-down and row-up results from the current cursor row.
   logic [ROW_W:0]   nr;
   logic [ROW_W-1:0] dn_row, dn_vt, up_row, up_vt;
   logic             dn_scroll;

   // Logical history row to physical row of the rotating store.
   function automatic logic [ROW_W-1:0] phys(input logic [ROW_W-1:0] base,
                                             input logic [ROW_W-1:0] r);
      logic [ROW_W:0] s;
      s = {1'b0, base} + {1'b0, r};
      if (32'(s) >= HISTORY_ROWS) begin
         s = s - (ROW_W + 1)'(HISTORY_ROWS);
      end
      return s[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                   input logic [COL_W-1:0] c);
      return ADDR_W'(32'(prow) * COLUMNS + 32'(c));
   endfunction

   // Column for the length of a line minus one, zero for an empty line.
   function automatic logic [COL_W-1:0] last_col(input logic [LEN_W-1:0] len);
      return (len == '0) ? '0 : COL_W'(len - LEN_W'(1));
   endfunction

   always_comb begin
      nr        = {1'b0, row_ff} + (ROW_W + 1)'(1);
      dn_scroll = (32'(nr) >= HISTORY_ROWS);
      dn_vt     = (32'(nr) >= SCREEN_ROWS) ? ROW_W'(32'(nr) - (SCREEN_ROWS - 1)) : vt_ff;
      dn_row    = ROW_W'(nr);
      if (dn_scroll) begin
         dn_row = ROW_W'(HISTORY_ROWS - 1);
         dn_vt  = ROW_W'(SCROLL_VT);
      end
      up_row = row_ff - ROW_W'(1);
      up_vt  = (up_row < vt_ff) ? up_row : vt_ff;
   end

   // Sequencer for one operation at a time.
   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      vt_in       = vt_ff;
      base_in     = base_ff;
      scan_row_in = scan_row_ff;
      sprow_in    = sprow_ff;
      x_in        = x_ff;
      chk_x_in    = chk_x_ff;
      chk_v_in    = 1'b0;
      len_in      = len_ff;
      phase_in    = phase_ff;
      cur_op_in   = cur_op_ff;
      cnt_in      = cnt_ff;
      cell_in     = '0;
      finish      = 1'b0;
      op_take     = 1'b0;
      wr_en       = 1'b0;
      wr_clear    = 1'b0;
      wr_scroll   = 1'b0;
      wr_col      = col_ff;
      wr_data     = {color_ff, ttcs_pkg::BLANK_CHAR};
      rd_row      = scan_row_ff;
      rd_col      = COL_W'(x_ff - LEN_W'(1));

      case (state_ff)
         S_CLEAR: begin
            wr_en    = 1'b1;
            wr_clear = 1'b1;
            cnt_in   = cnt_ff + ADDR_W'(1);
            if (32'(cnt_ff) == CELLS - 1) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            rd_row = ROW_W'(op_in.rr);
            rd_col = COL_W'(op_in.rc);
            if (op_valid && !rsp_v_ff) begin
               op_take   = 1'b1;
               cur_op_in = op_in;
               phase_in  = 1'b0;
               x_in      = LEN_W'(COLUMNS);
               case (op_in.op)
                  ttcs_pkg::OP_CHAR: begin
                     wr_en   = 1'b1;
                     wr_data = {color_ff, op_in.ch};
                     if (32'(col_ff) + 1 >= COLUMNS) begin
                        col_in = '0;
                        row_in = dn_row;
                        vt_in  = dn_vt;
                        if (dn_scroll) begin
                           base_in  = phys(base_ff, ROW_W'(1));
                           sprow_in = base_ff;
                           cnt_in   = '0;
                           state_in = S_SCROLL;
                        end else begin
                           finish = 1'b1;
                        end
                     end else begin
                        col_in = col_ff + COL_W'(1);
                        finish = 1'b1;
                     end
                  end
                  ttcs_pkg::OP_NEWLINE: begin
                     col_in = '0;
                     row_in = dn_row;
                     vt_in  = dn_vt;
                     if (dn_scroll) begin
                        base_in  = phys(base_ff, ROW_W'(1));
                        sprow_in = base_ff;
                        cnt_in   = '0;
                        state_in = S_SCROLL;
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  ttcs_pkg::OP_DELETE: begin
                     if (row_ff == '0 && col_ff == '0) begin
                        finish = 1'b1;
                     end else if (col_ff != '0) begin
                        col_in = col_ff - COL_W'(1);
                        wr_en  = 1'b1;
                        wr_col = col_ff - COL_W'(1);
                        finish = 1'b1;
                     end else begin
                        row_in      = up_row;
                        vt_in       = up_vt;
                        scan_row_in = up_row;
                        state_in    = S_SCAN;
                     end
                  end
                  ttcs_pkg::OP_LEFT: begin
                     if (col_ff == '0 && row_ff != '0) begin
                        row_in      = up_row;
                        vt_in       = up_vt;
                        scan_row_in = up_row;
                        phase_in    = 1'b1;
                        state_in    = S_SCAN;
                     end else if (col_ff != '0) begin
                        scan_row_in = row_ff;
                        state_in    = S_SCAN;
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  ttcs_pkg::OP_RIGHT: begin
                     scan_row_in = row_ff;
                     state_in    = S_SCAN;
                  end
                  ttcs_pkg::OP_UP: begin
                     if (row_ff != '0) begin
                        row_in      = up_row;
                        vt_in       = up_vt;
                        scan_row_in = up_row;
                        state_in    = S_SCAN;
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  ttcs_pkg::OP_DOWN: begin
                     if (!dn_scroll) begin
                        scan_row_in = ROW_W'(nr);
                        state_in    = S_SCAN;
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  ttcs_pkg::OP_READ: state_in = S_READ;
                  default: finish = 1'b1;
               endcase
            end
         end

         S_SCAN: begin
            // Reads go out right to left, one a cycle; data is checked in the cycle after its read.
            if (x_ff != '0) begin
               x_in     = x_ff - LEN_W'(1);
               chk_x_in = x_ff;
               chk_v_in = 1'b1;
            end
            if (chk_v_ff) begin
               if (rd_data[7:0] != ttcs_pkg::BLANK_CHAR) begin
                  len_in   = chk_x_ff;
                  state_in = S_POST;
               end else if (chk_x_ff == LEN_W'(1)) begin
                  len_in   = '0;
                  state_in = S_POST;
               end
            end
         end

         S_POST: begin
            x_in = LEN_W'(COLUMNS);
            case (cur_op_ff.op)
               ttcs_pkg::OP_DELETE: begin
                  col_in = (32'(len_ff) >= COLUMNS) ? COL_W'(COLUMNS - 1) : COL_W'(len_ff);
                  wr_en  = 1'b1;
                  wr_col = col_in;
                  finish = 1'b1;
               end
               ttcs_pkg::OP_LEFT: begin
                  if (phase_ff || LEN_W'(col_ff) > len_ff) begin
                     col_in = last_col(len_ff);
                  end else begin
                     col_in = col_ff - COL_W'(1);
                  end
                  finish = 1'b1;
               end
               ttcs_pkg::OP_RIGHT: begin
                  if (phase_ff) begin
                     if (len_ff != '0) begin
                        row_in = dn_row;
                        vt_in  = dn_vt;
                        col_in = '0;
                     end
                     finish = 1'b1;
                  end else if (LEN_W'(col_ff) < len_ff) begin
                     col_in = (32'(col_ff) + 1 >= COLUMNS) ? COL_W'(COLUMNS - 1)
                                                          : col_ff + COL_W'(1);
                     finish = 1'b1;
                  end else if (LEN_W'(col_ff) == len_ff && !dn_scroll) begin
                     scan_row_in = ROW_W'(nr);
                     phase_in    = 1'b1;
                     state_in    = S_SCAN;
                  end else begin
                     finish = 1'b1;
                  end
               end
               ttcs_pkg::OP_UP: begin
                  if (len_ff == '0) begin
                     col_in = '0;
                  end else if (LEN_W'(col_ff) > len_ff) begin
                     col_in = last_col(len_ff);
                  end
                  finish = 1'b1;
               end
               ttcs_pkg::OP_DOWN: begin
                  if (phase_ff) begin
                     col_in = last_col(len_ff);
                     finish = 1'b1;
                  end else if (len_ff != '0) begin
                     row_in = dn_row;
                     vt_in  = dn_vt;
                     if (LEN_W'(col_ff) > len_ff) begin
                        col_in = last_col(len_ff);
                     end
                     finish = 1'b1;
                  end else begin
                     scan_row_in = row_ff;
                     phase_in    = 1'b1;
                     state_in    = S_SCAN;
                  end
               end
               default: finish = 1'b1;
            endcase
         end

         S_SCROLL: begin
            // Blank the row that became the bottom of the history.
            wr_en     = 1'b1;
            wr_scroll = 1'b1;
            wr_col    = COL_W'(cnt_ff);
            cnt_in    = cnt_ff + ADDR_W'(1);
            if (32'(cnt_ff) == COLUMNS - 1) begin
               finish = 1'b1;
            end
         end

         S_READ: begin
            cell_in = rd_data;
            finish  = 1'b1;
         end

         default: state_in = S_IDLE;
      endcase

      if (finish) begin
         state_in = S_IDLE;
      end
   end

   // Address generation for both memory ports.
   always_comb begin
      if (wr_clear) begin
         wr_addr = cnt_ff;
      end else if (wr_scroll) begin
         wr_addr = cell_addr(sprow_ff, wr_col);
      end else begin
         wr_addr = cell_addr(phys(base_ff, row_ff), wr_col);
      end
      rd_addr = cell_addr(phys(base_ff, rd_row), rd_col);
   end

   ttcs_ram #(
      .WIDTH (16),
      .DEPTH (CELLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_clear ? {ttcs_pkg::RESET_COLOR, ttcs_pkg::BLANK_CHAR} : wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         row_ff   <= '0;
         col_ff   <= '0;
         vt_ff    <= '0;
         base_ff  <= '0;
         cnt_ff   <= '0;
         chk_v_ff <= 1'b0;
         phase_ff <= 1'b0;
         x_ff     <= LEN_W'(COLUMNS);
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         vt_ff    <= vt_in;
         base_ff  <= base_in;
         cnt_ff   <= cnt_in;
         chk_v_ff <= chk_v_in;
         phase_ff <= phase_in;
         x_ff     <= x_in;
         if (finish) begin
            rsp_v_ff <= 1'b1;
         end else if (pop && rsp_v_ff) begin
            rsp_v_ff <= 1'b0;
         end
      end
      scan_row_ff <= scan_row_in;
      sprow_ff    <= sprow_in;
      chk_x_ff    <= chk_x_in;
      len_ff      <= len_in;
      cur_op_ff   <= cur_op_in;
      // Result register, loaded as an operation completes.
      if (finish) begin
         rsp_cursor_col   <= 7'(col_in);
         rsp_cursor_row   <= 6'(row_in);
         rsp_screen_row   <= 5'(row_in - vt_in);
         rsp_viewport_top <= 6'(vt_in);
         rsp_cell_data    <= cell_in;
      end
   end

   // Text color register.
   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= ttcs_pkg::RESET_COLOR;
      end else if (csr_wr_en) begin
         color_ff <= csr_wr_data;
      end
   end

   assign empty = !rsp_v_ff;

endmodule

// ===== hdl/text_terminal_cursor_scrollback.sv =====
// Terminal engine: one result per item, in order, one item carried out at a time.
// Characters, newlines and items that need no line length finish straight from idle, and
// reads pass through a read state; a line-length scan runs at one cell a cycle, also for
// an arrow that scans two rows; a scroll adds a pass that blanks the new bottom row.
// The next item starts the cycle after the previous result is popped.
// Reset is synchronous; a clearing pass after reset blanks every cell of the history.
module text_terminal_cursor_scrollback #(
   parameter int COLUMNS      = ttcs_pkg::COLUMNS_DEF,
   parameter int SCREEN_ROWS  = ttcs_pkg::SCREEN_ROWS_DEF,
   parameter int HISTORY_ROWS = ttcs_pkg::HISTORY_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_char_code,
   input  logic [1:0]  req_direction,
   input  logic [5:0]  req_read_row,
   input  logic [6:0]  req_read_col,
   output logic        empty,
   input  logic        pop,
   output logic [6:0]  rsp_cursor_col,
   output logic [5:0]  rsp_cursor_row,
   output logic [4:0]  rsp_screen_row,
   output logic [5:0]  rsp_viewport_top,
   output logic [15:0] rsp_cell_data,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic             op_valid, op_take;
   ttcs_pkg::op_type op;

   ttcs_front #(
      .COLUMNS      (COLUMNS),
      .HISTORY_ROWS (HISTORY_ROWS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_kind      (req_kind),
      .req_char_code (req_char_code),
      .req_direction (req_direction),
      .req_read_row  (req_read_row),
      .req_read_col  (req_read_col),
      .op_valid      (op_valid),
      .op_out        (op),
      .op_take       (op_take)
   );

   ttcs_back #(
      .COLUMNS      (COLUMNS),
      .SCREEN_ROWS  (SCREEN_ROWS),
      .HISTORY_ROWS (HISTORY_ROWS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .op_valid         (op_valid),
      .op_in            (op),
      .op_take          (op_take),
      .empty            (empty),
      .pop              (pop),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_screen_row   (rsp_screen_row),
      .rsp_viewport_top (rsp_viewport_top),
      .rsp_cell_data    (rsp_cell_data)
   );

endmodule
